>>> hw/rtl/bahc_pkg.sv
// ----------------------------------------------------------------------------
// bahc_pkg
// widths, register codes, arctangent table and sideband type for the ball
// approach heading and capture unit
// ----------------------------------------------------------------------------
package bahc_pkg;

	// field widths
	localparam int POS_W   = 16;  // positions in mm
	localparam int HEAD_W  = 13;  // robot heading, tenths of a degree
	localparam int TGT_W   = 14;  // target heading
	localparam int DIFF_W  = POS_W + 1;
	localparam int WIN_W   = 11;
	localparam int LIM_W   = 10;
	localparam int MAG_W   = 11;  // bearing magnitude, 0..1800
	localparam int BRG_W   = MAG_W + 1;

	// stream widths
	localparam int S_DATA_W = 80;
	localparam int M_DATA_W = 48;

	// configuration port
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = WIN_W;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_ANGLE_WINDOW   = 4'd0;
	localparam cfg_idx_t CFG_CAPTURE_X      = 4'd1;
	localparam cfg_idx_t CFG_CAPTURE_Y_TOL  = 4'd2;
	localparam cfg_idx_t CFG_DRIBBLER_OFS   = 4'd3;

	localparam logic [WIN_W-1:0] ANGLE_WINDOW_RST  = 11'd200;
	localparam logic [LIM_W-1:0] CAPTURE_X_RST     = 10'd40;
	localparam logic [LIM_W-1:0] CAPTURE_Y_TOL_RST = 10'd20;
	localparam logic [LIM_W-1:0] DRIBBLER_OFS_RST  = 10'd100;

	// cordic datapath
	localparam int FRAC_W  = 24;  // start vector is magnitude times 2^24
	localparam int CW      = 44;  // x/y width, covers the cordic gain
	localparam int ZW      = 28;  // angle accumulator, 2^-16 tenth of a degree
	localparam int ZFRAC_W = 16;
	localparam int TAB_LEN = 24;

	localparam logic [MAG_W-1:0] ALPHA_MAX    = 11'd900;
	localparam logic [MAG_W-1:0] HALF_TURN    = 11'd1800;
	localparam logic [MAG_W-1:0] BEHIND_BRG   = 11'd1799;

	// atan(2^-i) in 2^-16 tenths of a degree, rounded to nearest
	localparam logic signed [ZW-1:0] ATAN_TAB [TAB_LEN] = '{
		28'sd29491200, 28'sd17409672, 28'sd9198793, 28'sd4669451,
		28'sd2343786,  28'sd1173036,  28'sd586661,  28'sd293348,
		28'sd146676,   28'sd73339,    28'sd36669,   28'sd18335,
		28'sd9167,     28'sd4584,     28'sd2292,    28'sd1146,
		28'sd573,      28'sd286,      28'sd143,     28'sd72,
		28'sd36,       28'sd18,       28'sd9,       28'sd4
	};

	// fields that ride alongside the cordic
	typedef struct packed {
		logic [POS_W-1:0]         ball_x;
		logic [POS_W-1:0]         ball_y;
		logic signed [HEAD_W-1:0] head;
		logic                     dx_zero;
		logic                     dx_pos;
		logic                     dy_neg;
		logic                     dy_pos;
		logic                     cap;
	} side_t;

endpackage

>>> hw/rtl/ball_approach_heading_and_capture_unit.sv
// ----------------------------------------------------------------------------
// ball_approach_heading_and_capture_unit
// bearing to the ball by pipelined cordic, drive mode choice and capture check
// ----------------------------------------------------------------------------
// Each enabled sample beat gives exactly one result beat; a beat with enable
// low is taken and dropped. The unit is fully pipelined: a new sample may be
// taken every cycle, and a result appears min(CORDIC_STEPS, 24) + 4 cycles
// after its sample, set by one register stage per cordic iteration plus two
// stages in front (differences, then magnitudes and capture check) and two
// behind (rounding, then bearing, window compare and heading sum). The whole
// pipeline holds while the output register is full and not taken, so
// s_tready follows m_tready whenever a result is waiting. Bearing is
// -atan2(dx, dy) in tenths of a degree; when dx is zero it is 0 for dy > 0,
// else 1799. Configuration writes are taken every cycle and should only be
// made while no sample is in flight.
module ball_approach_heading_and_capture_unit
	import bahc_pkg::*;
#(
	parameter int CORDIC_STEPS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// sample stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// ball_x, ball_y, robot_x, robot_y, robot_heading, zero pad
	input  logic [S_DATA_W-1:0]   s_tdata,
	// enable
	input  logic [0:0]            s_tuser,
	// result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// target_x, target_y, target_heading, captured, zero pad
	output logic [M_DATA_W-1:0]   m_tdata,
	// drive_mode
	output logic [0:0]            m_tuser,
	// configuration writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// iterations actually run: the angle table has 24 entries
	localparam int NIT = (CORDIC_STEPS > TAB_LEN) ? TAB_LEN : CORDIC_STEPS;

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic [WIN_W-1:0] angle_window_q;
	logic [LIM_W-1:0] capture_x_limit_q;
	logic [LIM_W-1:0] capture_y_tol_q;
	logic [LIM_W-1:0] dribbler_ofs_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_window_q    <= ANGLE_WINDOW_RST;
			capture_x_limit_q <= CAPTURE_X_RST;
			capture_y_tol_q   <= CAPTURE_Y_TOL_RST;
			dribbler_ofs_q    <= DRIBBLER_OFS_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_ANGLE_WINDOW:  angle_window_q    <= cfg_data;
				CFG_CAPTURE_X:     capture_x_limit_q <= cfg_data[LIM_W-1:0];
				CFG_CAPTURE_Y_TOL: capture_y_tol_q   <= cfg_data[LIM_W-1:0];
				CFG_DRIBBLER_OFS:  dribbler_ofs_q    <= cfg_data[LIM_W-1:0];
				default: ;  // unknown index, write dropped
			endcase
		end
	end

	// ------------------------------------------------------------------
	// pipeline advance: everything moves unless the output beat is stuck
	// ------------------------------------------------------------------
	logic adv;
	logic vld_s5;

	assign adv      = !vld_s5 || m_tready;
	assign s_tready = adv;

	// input fields
	logic signed [POS_W-1:0]  in_ball_x, in_ball_y, in_robot_x, in_robot_y;
	logic signed [HEAD_W-1:0] in_head;

	assign in_ball_x  = s_tdata[POS_W-1:0];
	assign in_ball_y  = s_tdata[2*POS_W-1:POS_W];
	assign in_robot_x = s_tdata[3*POS_W-1:2*POS_W];
	assign in_robot_y = s_tdata[4*POS_W-1:3*POS_W];
	assign in_head    = s_tdata[4*POS_W+HEAD_W-1:4*POS_W];

	// ------------------------------------------------------------------
	// stage 1: position differences
	// ------------------------------------------------------------------
	logic                     vld_s1;
	logic signed [DIFF_W-1:0] dx_s1, dy_s1;
	logic [POS_W-1:0]         ball_x_s1, ball_y_s1;
	logic signed [HEAD_W-1:0] head_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			// disabled samples are taken but never enter the pipe
			vld_s1 <= s_tvalid && s_tuser[0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1     <= {in_ball_x[POS_W-1], in_ball_x} - {in_robot_x[POS_W-1], in_robot_x};
			dy_s1     <= {in_ball_y[POS_W-1], in_ball_y} - {in_robot_y[POS_W-1], in_robot_y};
			ball_x_s1 <= in_ball_x;
			ball_y_s1 <= in_ball_y;
			head_s1   <= in_head;
		end
	end

	// ------------------------------------------------------------------
	// stage 2: magnitudes, cordic start vector, capture window
	// ------------------------------------------------------------------
	logic [DIFF_W-1:0]     adx, ady;
	logic [DIFF_W-1:0]     cap_hi;
	logic signed [DIFF_W:0] cap_lo;
	logic signed [DIFF_W:0] dy_ext;
	logic                  cap_c;

	assign adx = dx_s1[DIFF_W-1] ? DIFF_W'(-dx_s1) : DIFF_W'(dx_s1);
	assign ady = dy_s1[DIFF_W-1] ? DIFF_W'(-dy_s1) : DIFF_W'(dy_s1);

	// offset +/- tolerance; the low bound may go negative
	assign cap_hi = DIFF_W'(dribbler_ofs_q) + DIFF_W'(capture_y_tol_q);
	assign cap_lo = $signed((DIFF_W+1)'(dribbler_ofs_q)) - $signed((DIFF_W+1)'(capture_y_tol_q));
	assign dy_ext = {dy_s1[DIFF_W-1], dy_s1};
	assign cap_c  = (adx < DIFF_W'(capture_x_limit_q))
		&& (dy_ext < $signed({1'b0, cap_hi}))
		&& (dy_ext > cap_lo);

	logic                  vld_s2;
	logic signed [CW-1:0]  x_s2, y_s2;
	side_t                 side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s2 <= {{(CW-DIFF_W-FRAC_W){1'b0}}, ady, {FRAC_W{1'b0}}};
			y_s2 <= {{(CW-DIFF_W-FRAC_W){1'b0}}, adx, {FRAC_W{1'b0}}};
			side_s2.ball_x  <= ball_x_s1;
			side_s2.ball_y  <= ball_y_s1;
			side_s2.head    <= head_s1;
			side_s2.dx_zero <= (dx_s1 == '0);
			side_s2.dx_pos  <= !dx_s1[DIFF_W-1] && (dx_s1 != '0);
			side_s2.dy_neg  <= dy_s1[DIFF_W-1];
			side_s2.dy_pos  <= !dy_s1[DIFF_W-1] && (dy_s1 != '0);
			side_s2.cap     <= cap_c;
		end
	end

	// ------------------------------------------------------------------
	// stage 3: vectoring cordic, one iteration per register stage
	// ------------------------------------------------------------------
	logic                 vld_s3 [NIT];
	logic signed [CW-1:0] x_s3   [NIT];
	logic signed [CW-1:0] y_s3   [NIT];
	logic signed [ZW-1:0] z_s3   [NIT];
	side_t                side_s3 [NIT];

	for (genvar i = 0; i < NIT; i++) begin : g_iter
		logic                 vi;
		logic signed [CW-1:0] xi, yi, xsh, ysh;
		logic signed [ZW-1:0] zi;
		side_t                si;

		if (i == 0) begin : g_first
			assign vi = vld_s2;
			assign xi = x_s2;
			assign yi = y_s2;
			assign zi = '0;
			assign si = side_s2;
		end else begin : g_next
			assign vi = vld_s3[i-1];
			assign xi = x_s3[i-1];
			assign yi = y_s3[i-1];
			assign zi = z_s3[i-1];
			assign si = side_s3[i-1];
		end

		// arithmetic shifts floor, as the angle must match bit for bit
		assign xsh = xi >>> i;
		assign ysh = yi >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s3[i] <= 1'b0;
			end else if (adv) begin
				vld_s3[i] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				// rotate towards y = 0
				if (!yi[CW-1]) begin
					x_s3[i] <= xi + ysh;
					y_s3[i] <= yi - xsh;
					z_s3[i] <= zi + ATAN_TAB[i];
				end else begin
					x_s3[i] <= xi - ysh;
					y_s3[i] <= yi + xsh;
					z_s3[i] <= zi - ATAN_TAB[i];
				end
				side_s3[i] <= si;
			end
		end
	end

	// ------------------------------------------------------------------
	// stage 4: round the angle to tenths, clamp, fold into a magnitude
	// ------------------------------------------------------------------
	logic signed [ZW-1:0]       z_fin;
	logic signed [ZW-1:0]       z_rnd;
	logic [ZW-ZFRAC_W-1:0]      alpha_w;
	logic [MAG_W-1:0]           alpha;
	logic [MAG_W-1:0]           mag_c;
	side_t                      side_fin;

	assign z_fin    = z_s3[NIT-1];
	assign side_fin = side_s3[NIT-1];
	// round half up; negative angles clamp to zero
	assign z_rnd    = z_fin + ZW'(1 << (ZFRAC_W - 1));
	assign alpha_w  = z_fin[ZW-1] ? '0 : z_rnd[ZW-1:ZFRAC_W];
	assign alpha    = (alpha_w > (ZW-ZFRAC_W)'(ALPHA_MAX)) ? ALPHA_MAX : MAG_W'(alpha_w);

	always_comb begin
		if (side_fin.dx_zero) begin
			// ball straight ahead or straight behind
			mag_c = side_fin.dy_pos ? '0 : BEHIND_BRG;
		end else if (side_fin.dy_neg) begin
			mag_c = HALF_TURN - alpha;
		end else begin
			mag_c = alpha;
		end
	end

	logic             vld_s4;
	logic [MAG_W-1:0] mag_s4;
	side_t            side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= vld_s3[NIT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s4  <= mag_c;
			side_s4 <= side_fin;
		end
	end

	// ------------------------------------------------------------------
	// stage 5: bearing sign, window compare, heading sum, output register
	// ------------------------------------------------------------------
	logic signed [BRG_W-1:0] bearing;
	logic signed [TGT_W-1:0] tgt_c;
	logic                    pos_c;

	// ball to the right (dx > 0) gives a negative bearing
	assign bearing = side_s4.dx_pos ? -$signed({1'b0, mag_s4}) : $signed({1'b0, mag_s4});
	assign tgt_c   = TGT_W'(bearing) + TGT_W'(side_s4.head);
	assign pos_c   = mag_s4 < angle_window_q;

	logic [M_DATA_W-1:0] tdata_s5;
	logic                mode_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s5  <= pos_c;
			tdata_s5 <= {1'b0, side_s4.cap, tgt_c,
				pos_c ? side_s4.ball_y : {POS_W{1'b0}},
				pos_c ? side_s4.ball_x : {POS_W{1'b0}}};
		end
	end

	assign m_tvalid   = vld_s5;
	assign m_tdata    = tdata_s5;
	assign m_tuser[0] = mode_s5;

endmodule

>>> hw/rtl/bahc_checker.sv
// ----------------------------------------------------------------------------
// bahc_checker
// port level checks for the ball approach heading and capture unit
// ----------------------------------------------------------------------------
module bahc_checker
	import bahc_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                s_tready,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [M_DATA_W-1:0] m_tdata,
	input logic [0:0]          m_tuser
);

	// a waiting result beat holds still
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// the sample side only stalls behind a stuck result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without a stuck result");

	// turn in place carries a zero position setpoint
	a_turn_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[2*POS_W-1:0] == '0)
		else $error("turn in place with non-zero setpoint");

	// target heading stays within bearing plus heading limits (1800 + 4096)
	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[2*POS_W+TGT_W-1:2*POS_W]) <= 14'sd5896)
			&& ($signed(m_tdata[2*POS_W+TGT_W-1:2*POS_W]) >= -14'sd5896))
		else $error("target heading out of range");

endmodule

bind ball_approach_heading_and_capture_unit bahc_checker u_bahc_checker (.*);
